// ----- rtl/core/latin_grapheme_to_phoneme_unit_macros.svh -----
// assertion shorthands shared by the rtl of the grapheme-to-phoneme unit
`ifndef LATIN_GRAPHEME_TO_PHONEME_UNIT_MACROS_SVH
`define LATIN_GRAPHEME_TO_PHONEME_UNIT_MACROS_SVH

// condition must never hold out of reset
`define LGP_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LGP_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/lgp_pkg.sv -----
`timescale 1ns / 1ps
package lgp_pkg;

	localparam int LGP_LOOKAHEAD = 3;
	localparam int LGP_QUEUE_DEPTH = 4;
	localparam int LGP_OUT_DEPTH = 4;

	localparam logic [1:0] LGP_LANG_FR = 2'd1;
	localparam logic [1:0] LGP_LANG_PT = 2'd2;

	localparam logic [9:0] LGP_PH_TAP = 10'h27E;
	localparam logic [9:0] LGP_PH_ESH = 10'h283;
	localparam logic [9:0] LGP_PH_LJ = 10'h28E;
	localparam logic [9:0] LGP_PH_NJ = 10'h272;
	localparam logic [9:0] LGP_PH_UVR = 10'h281;
	localparam logic [9:0] LGP_PH_EZH = 10'h292;
	localparam logic [9:0] LGP_PH_ONAS = 10'h0F5;
	localparam logic [9:0] LGP_PH_ANAS = 10'h0E3;
	localparam logic [9:0] LGP_PH_OSL = 10'h0F8;
	localparam logic [9:0] LGP_PH_SPACE = 10'h020;

	typedef enum logic [2:0] {
		LGP_K_LETTER,
		LGP_K_PUNCT,
		LGP_K_OPEN,
		LGP_K_DROP,
		LGP_K_EOT
	} lgp_kind_t;

	typedef struct packed {
		lgp_kind_t kind;
		logic [12:0] val;
	} lgp_item_t;

	typedef struct packed {
		logic [20:0] codepoint;
		logic end_of_text;
	} lgp_in_t;

	typedef struct packed {
		logic [9:0] phoneme;
		logic text_end;
		logic last_of_run;
	} lgp_out_t;

	typedef struct packed {
		logic [1:0] language;
	} lgp_cfg_t;

	// outcome of one window step: up to two phonemes, two marks a digraph
	typedef struct packed {
		logic [1:0] n;
		logic [9:0] p0;
		logic [9:0] p1;
		logic two;
	} lgp_rule_t;

	function automatic logic lgp_is_vowel(input logic [12:0] c);
		case (c) inside
			13'h061, 13'h065, 13'h069, 13'h06F, 13'h075, 13'h079,
			13'h0E0, 13'h0E1, 13'h0E2, 13'h0E3, 13'h0E8, 13'h0E9,
			13'h0EA, 13'h0EC, 13'h0ED, 13'h0EE, 13'h0F2, 13'h0F3,
			13'h0F4, 13'h0F5, 13'h0F9, 13'h0FA, 13'h0FB, 13'h0FC,
			13'h0E6, 13'h0F8, 13'h153, 13'h129, 13'h1EBD: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic lgp_is_front(input logic [12:0] c);
		case (c) inside
			13'h065, 13'h069, 13'h079, 13'h0E9, 13'h0EA, 13'h0E8,
			13'h0ED, 13'h0EE, 13'h0EF: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic lgp_rule_t lgp_r1(input logic [9:0] a, input logic dg);
		lgp_rule_t r;
		r = '0;
		r.n = 2'd1;
		r.p0 = a;
		r.two = dg;
		return r;
	endfunction

	function automatic lgp_rule_t lgp_r2(input logic [9:0] a, input logic [9:0] b,
			input logic dg);
		lgp_rule_t r;
		r = '0;
		r.n = 2'd2;
		r.p0 = a;
		r.p1 = b;
		r.two = dg;
		return r;
	endfunction

	function automatic lgp_rule_t lgp_rule_es(input logic [12:0] c, input logic [12:0] n1,
			input logic [12:0] n2, input logic start, input logic last);
		lgp_rule_t r;
		r = '0;
		if (c == 13'h063 && n1 == 13'h068) r = lgp_r2(10'h074, LGP_PH_ESH, 1'b1);
		else if (c == 13'h06C && n1 == 13'h06C) r = lgp_r1(LGP_PH_LJ, 1'b1);
		else if (c == 13'h072 && n1 == 13'h072) r = lgp_r1(10'h072, 1'b1);
		else if (c == 13'h071 && n1 == 13'h075) r = lgp_r1(10'h06B, 1'b1);
		else if (c == 13'h067 && n1 == 13'h075 && lgp_is_front(n2))
			r = lgp_r1(10'h067, 1'b1);
		else begin
			case (c) inside
				13'h061, 13'h0E1: r = lgp_r1(10'h061, 1'b0);
				13'h065, 13'h0E9: r = lgp_r1(10'h065, 1'b0);
				13'h069, 13'h0ED: r = lgp_r1(10'h069, 1'b0);
				13'h06F, 13'h0F3: r = lgp_r1(10'h06F, 1'b0);
				13'h075, 13'h0FA, 13'h0FC: r = lgp_r1(10'h075, 1'b0);
				13'h062, 13'h076: r = lgp_r1(10'h062, 1'b0);
				13'h063: r = lgp_r1(lgp_is_front(n1) ? 10'h073 : 10'h06B, 1'b0);
				13'h067: r = lgp_r1(lgp_is_front(n1) ? 10'h078 : 10'h067, 1'b0);
				13'h06A: r = lgp_r1(10'h078, 1'b0);
				13'h064, 13'h066, 13'h06B, 13'h06C, 13'h06D, 13'h06E,
				13'h070, 13'h073, 13'h074, 13'h077: r = lgp_r1(c[9:0], 1'b0);
				13'h0F1: r = lgp_r1(LGP_PH_NJ, 1'b0);
				13'h072: r = lgp_r1(start ? 10'h072 : LGP_PH_TAP, 1'b0);
				13'h078: r = lgp_r2(10'h06B, 10'h073, 1'b0);
				13'h079: r = lgp_r1(last ? 10'h069 : 10'h06A, 1'b0);
				13'h07A: r = lgp_r1(10'h073, 1'b0);
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	function automatic lgp_rule_t lgp_rule_fr(input logic [12:0] c, input logic [12:0] n1,
			input logic [12:0] n2, input logic last, input logic whas,
			input logic [9:0] wlast);
		lgp_rule_t r;
		logic n2_open;
		r = '0;
		n2_open = (n2 == '0) || !lgp_is_vowel(n2);
		if (c == 13'h063 && n1 == 13'h068) r = lgp_r1(LGP_PH_ESH, 1'b1);
		else if (c == 13'h067 && n1 == 13'h06E) r = lgp_r1(LGP_PH_NJ, 1'b1);
		else if (c == 13'h06F && n1 == 13'h075) r = lgp_r1(10'h075, 1'b1);
		else if (c == 13'h06F && n1 == 13'h06E && n2_open) r = lgp_r1(LGP_PH_ONAS, 1'b1);
		else if ((c == 13'h061 || c == 13'h065) && (n1 == 13'h06E || n1 == 13'h06D)
				&& n2_open) r = lgp_r1(LGP_PH_ANAS, 1'b1);
		else if (c == 13'h061 && n1 == 13'h075) r = lgp_r1(10'h06F, 1'b1);
		else if (c == 13'h065 && n1 == 13'h075) r = lgp_r1(LGP_PH_OSL, 1'b1);
		else if (c == 13'h071 && n1 == 13'h075) r = lgp_r1(10'h06B, 1'b1);
		else if (c == 13'h06F && n1 == 13'h069) r = lgp_r2(10'h077, 10'h061, 1'b1);
		else begin
			case (c) inside
				13'h061, 13'h0E0, 13'h0E2: r = lgp_r1(10'h061, 1'b0);
				13'h062, 13'h064, 13'h070, 13'h074, 13'h07A, 13'h06D, 13'h06E:
					if (!last) r = lgp_r1(c[9:0], 1'b0);
				13'h063: r = lgp_r1(lgp_is_front(n1) ? 10'h073 : 10'h06B, 1'b0);
				13'h065, 13'h0E8, 13'h0E9, 13'h0EA, 13'h0EB:
					if (!last) r = lgp_r1(10'h065, 1'b0);
				13'h066, 13'h06B, 13'h06C, 13'h076: r = lgp_r1(c[9:0], 1'b0);
				13'h067: r = lgp_r1(lgp_is_front(n1) ? LGP_PH_EZH : 10'h067, 1'b0);
				13'h069, 13'h0EE, 13'h0EF, 13'h079: r = lgp_r1(10'h069, 1'b0);
				13'h06A: r = lgp_r1(LGP_PH_EZH, 1'b0);
				13'h06F, 13'h0F4, 13'h0F6: r = lgp_r1(10'h06F, 1'b0);
				13'h071: r = lgp_r1(10'h06B, 1'b0);
				13'h072: r = lgp_r1(LGP_PH_UVR, 1'b0);
				13'h073: begin
					// intervocalic s voices
					if (!last) r = lgp_r1((whas && lgp_is_vowel({3'b000, wlast})
						&& lgp_is_vowel(n1)) ? 10'h07A : 10'h073, 1'b0);
				end
				13'h075, 13'h0F9, 13'h0FB, 13'h0FC: r = lgp_r1(10'h079, 1'b0);
				13'h078: if (!last) r = lgp_r2(10'h06B, 10'h073, 1'b0);
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	function automatic lgp_rule_t lgp_rule_pt(input logic [12:0] c, input logic [12:0] n1,
			input logic [12:0] n2, input logic start);
		lgp_rule_t r;
		r = '0;
		if (c == 13'h06C && n1 == 13'h068) r = lgp_r1(LGP_PH_LJ, 1'b1);
		else if (c == 13'h06E && n1 == 13'h068) r = lgp_r1(LGP_PH_NJ, 1'b1);
		else if (c == 13'h063 && n1 == 13'h068) r = lgp_r1(LGP_PH_ESH, 1'b1);
		else if (c == 13'h072 && n1 == 13'h072) r = lgp_r1(LGP_PH_UVR, 1'b1);
		else if (c == 13'h073 && n1 == 13'h073) r = lgp_r1(10'h073, 1'b1);
		else if (c == 13'h071 && n1 == 13'h075) r = lgp_r1(10'h06B, 1'b1);
		else if (c == 13'h067 && n1 == 13'h075 && lgp_is_front(n2))
			r = lgp_r1(10'h067, 1'b1);
		else begin
			case (c) inside
				13'h061, 13'h0E0, 13'h0E1, 13'h0E2: r = lgp_r1(10'h061, 1'b0);
				13'h0E3: r = lgp_r1(LGP_PH_ANAS, 1'b0);
				13'h065, 13'h0E9, 13'h0EA: r = lgp_r1(10'h065, 1'b0);
				13'h069, 13'h0ED: r = lgp_r1(10'h069, 1'b0);
				13'h06F, 13'h0F3, 13'h0F4: r = lgp_r1(10'h06F, 1'b0);
				13'h0F5: r = lgp_r1(LGP_PH_ONAS, 1'b0);
				13'h075, 13'h0FA: r = lgp_r1(10'h075, 1'b0);
				13'h063: r = lgp_r1(lgp_is_front(n1) ? 10'h073 : 10'h06B, 1'b0);
				13'h0E7: r = lgp_r1(10'h073, 1'b0);
				13'h067: r = lgp_r1(lgp_is_front(n1) ? LGP_PH_EZH : 10'h067, 1'b0);
				13'h06A: r = lgp_r1(LGP_PH_EZH, 1'b0);
				13'h062, 13'h064, 13'h066, 13'h06B, 13'h06C, 13'h06D, 13'h06E,
				13'h070, 13'h073, 13'h074, 13'h076, 13'h07A: r = lgp_r1(c[9:0], 1'b0);
				13'h072: r = lgp_r1(start ? LGP_PH_UVR : LGP_PH_TAP, 1'b0);
				13'h078: r = lgp_r1(LGP_PH_ESH, 1'b0);
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	function automatic lgp_rule_t lgp_rule(input logic [1:0] lang, input logic [12:0] c,
			input logic [12:0] n1, input logic [12:0] n2, input logic start,
			input logic last, input logic whas, input logic [9:0] wlast);
		if (lang == LGP_LANG_FR) return lgp_rule_fr(c, n1, n2, last, whas, wlast);
		else if (lang == LGP_LANG_PT) return lgp_rule_pt(c, n1, n2, start);
		else return lgp_rule_es(c, n1, n2, start, last);
	endfunction

endpackage

// ----- rtl/core/lgp_chan_if.sv -----
`timescale 1ns / 1ps
interface lgp_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/lgp_fifo.sv -----
`timescale 1ns / 1ps
`include "latin_grapheme_to_phoneme_unit_macros.svh"
module lgp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`LGP_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "push into full queue")
	`LGP_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty, "pop from empty queue")
	`LGP_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "fill count too big")
endmodule

// ----- rtl/core/lgp_front.sv -----
`timescale 1ns / 1ps
module lgp_front #(
	parameter int QUEUE_DEPTH = lgp_pkg::LGP_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	lgp_chan_if.sink codepoints,
	output lgp_pkg::lgp_item_t item,
	output logic item_empty,
	input logic item_pop
);
	import lgp_pkg::*;

	logic [20:0] cp;
	logic letter;
	logic q_full;
	lgp_item_t cls;
	logic [$bits(lgp_item_t)-1:0] q_rdata;

	assign cp = codepoints.data.codepoint;

	always_comb begin
		letter = (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A) ||
			(cp >= 21'hC0 && cp <= 21'hFF) || cp == 21'h107 || cp == 21'h10D ||
			cp == 21'h119 || cp == 21'h11A || cp == 21'h129 || cp == 21'h153 ||
			cp == 21'h1EBD;
		cls.val = cp[12:0];
		if (codepoints.data.end_of_text) begin
			cls.kind = LGP_K_EOT;
		end else if (letter) begin
			cls.kind = LGP_K_LETTER;
			// fold upper case: ASCII capitals and the Latin-1 capitals C0-C4, C7-CF, D1-D6, D9-DC
			if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'hC0 && cp <= 21'hC4) ||
					(cp >= 21'hC7 && cp <= 21'hCF) || (cp >= 21'hD1 && cp <= 21'hD6) ||
					(cp >= 21'hD9 && cp <= 21'hDC))
				cls.val = cp[12:0] + 13'd32;
		end else begin
			case (cp) inside
				21'h2C, 21'h2E, 21'h3B, 21'h3A, 21'h21, 21'h3F, 21'h2D, 21'h27,
				21'h29, 21'hBB: cls.kind = LGP_K_PUNCT;
				21'h28, 21'hA1, 21'hBF, 21'hAB: cls.kind = LGP_K_OPEN;
				default: cls.kind = LGP_K_DROP;
			endcase
		end
	end

	assign codepoints.ready = !q_full;

	lgp_fifo #(.WIDTH($bits(lgp_item_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(codepoints.valid && !q_full),
		.wdata(cls),
		.full(q_full),
		.pop(item_pop),
		.rdata(q_rdata),
		.empty(item_empty)
	);

	assign item = lgp_item_t'(q_rdata);
endmodule

// ----- rtl/core/lgp_back.sv -----
`timescale 1ns / 1ps
`include "latin_grapheme_to_phoneme_unit_macros.svh"
module lgp_back (
	input logic clk,
	input logic arst_n,
	input logic [1:0] lang,
	input lgp_pkg::lgp_item_t item,
	input logic item_empty,
	output logic item_pop,
	input logic out_full,
	output logic push,
	output lgp_pkg::lgp_out_t push_data
);
	import lgp_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_EMIT = 3'd2;
	localparam logic [2:0] S_TAIL = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	function automatic logic [2:0] next_of(input lgp_kind_t k, input logic [1:0] n);
		if (k == LGP_K_LETTER) return S_DONE;
		else if (n != 2'd0) return S_EVAL;
		else return S_TAIL;
	endfunction

	logic [2:0] state_q, state_d;
	logic [1:0] cnt_q, cnt_d;
	logic start_q, start_d;
	logic [9:0] wlast_q, wlast_d;
	logic whas_q, whas_d;
	logic nsp_q, nsp_d;
	logic seqne_q, seqne_d;
	logic held_vld_q, held_vld_d;
	logic [1:0] idx_q, idx_d;
	logic [1:0] ecnt_q, ecnt_d;
	logic [12:0] win_q [LGP_LOOKAHEAD];
	logic [12:0] win_d [LGP_LOOKAHEAD];
	logic [9:0] e_q [3];
	logic [9:0] e_d [3];
	lgp_kind_t kind_q, kind_d;
	logic [12:0] val_q, val_d;
	logic [9:0] held_ph_q, held_ph_d;
	logic held_end_q, held_end_d;

	logic adv;
	logic [12:0] n1, n2;
	lgp_rule_t rule;
	logic [1:0] cnt_step;
	logic space;
	logic prod_vld, prod_end, fin;
	logic [9:0] prod_ph;

	assign adv = !out_full;

	always_comb begin
		n1 = (cnt_q > 2'd1) ? win_q[1] : '0;
		n2 = (cnt_q > 2'd2) ? win_q[2] : '0;
		rule = lgp_rule(lang, win_q[0], n1, n2, start_q, cnt_q == 2'd1, whas_q, wlast_q);
		cnt_step = cnt_q - (rule.two ? 2'd2 : 2'd1);
		space = (rule.n != 2'd0) && !whas_q && seqne_q && nsp_q;
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		start_d = start_q;
		wlast_d = wlast_q;
		whas_d = whas_q;
		nsp_d = nsp_q;
		seqne_d = seqne_q;
		idx_d = idx_q;
		ecnt_d = ecnt_q;
		win_d = win_q;
		e_d = e_q;
		kind_d = kind_q;
		val_d = val_q;
		item_pop = 1'b0;
		prod_vld = 1'b0;
		prod_ph = '0;
		prod_end = 1'b0;
		fin = 1'b0;
		if (adv) begin
			unique case (state_q)
				S_IDLE: begin
					if (!item_empty) begin
						item_pop = 1'b1;
						kind_d = item.kind;
						val_d = item.val;
						if (item.kind == LGP_K_LETTER) begin
							win_d[cnt_q] = item.val;
							cnt_d = cnt_q + 2'd1;
							if (cnt_q == 2'(LGP_LOOKAHEAD - 1)) state_d = S_EVAL;
						end else if (cnt_q != 2'd0) begin
							state_d = S_EVAL;
						end else begin
							state_d = S_TAIL;
						end
					end
				end
				S_EVAL: begin
					cnt_d = cnt_step;
					start_d = 1'b0;
					if (rule.two) begin
						win_d[0] = win_q[2];
					end else begin
						win_d[0] = win_q[1];
						win_d[1] = win_q[2];
					end
					if (rule.n != 2'd0) begin
						whas_d = 1'b1;
						seqne_d = 1'b1;
						wlast_d = (rule.n == 2'd2) ? rule.p1 : rule.p0;
					end
					if (space) begin
						e_d[0] = LGP_PH_SPACE;
						e_d[1] = rule.p0;
						e_d[2] = rule.p1;
						ecnt_d = rule.n + 2'd1;
					end else begin
						e_d[0] = rule.p0;
						e_d[1] = rule.p1;
						ecnt_d = rule.n;
					end
					idx_d = '0;
					// word closed: next word starts fresh and wants a space
					if (kind_q != LGP_K_LETTER && cnt_step == 2'd0) begin
						nsp_d = 1'b1;
						whas_d = 1'b0;
						wlast_d = '0;
						start_d = 1'b1;
					end
					if (rule.n != 2'd0) state_d = S_EMIT;
					else state_d = next_of(kind_q, cnt_step);
				end
				S_EMIT: begin
					prod_vld = 1'b1;
					prod_ph = e_q[idx_q];
					idx_d = idx_q + 2'd1;
					if (idx_q == ecnt_q - 2'd1) state_d = next_of(kind_q, cnt_q);
				end
				S_TAIL: begin
					case (kind_q)
						LGP_K_PUNCT: begin
							prod_vld = 1'b1;
							prod_ph = val_q[9:0];
							seqne_d = 1'b1;
							nsp_d = 1'b1;
						end
						LGP_K_OPEN: begin
							prod_vld = 1'b1;
							prod_ph = val_q[9:0];
							seqne_d = 1'b1;
							nsp_d = 1'b0;
						end
						LGP_K_EOT: begin
							prod_vld = 1'b1;
							prod_end = 1'b1;
							cnt_d = '0;
							start_d = 1'b1;
							wlast_d = '0;
							whas_d = 1'b0;
							nsp_d = 1'b0;
							seqne_d = 1'b0;
						end
						default: ;
					endcase
					state_d = S_DONE;
				end
				S_DONE: begin
					fin = 1'b1;
					state_d = S_IDLE;
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	// one result is held back so the last one of an item can be marked
	always_comb begin
		push = held_vld_q && (prod_vld || fin);
		push_data.phoneme = held_ph_q;
		push_data.text_end = held_end_q;
		push_data.last_of_run = fin;
		held_vld_d = held_vld_q;
		held_ph_d = held_ph_q;
		held_end_d = held_end_q;
		if (prod_vld) begin
			held_vld_d = 1'b1;
			held_ph_d = prod_ph;
			held_end_d = prod_end;
		end else if (fin) begin
			held_vld_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
		e_q <= e_d;
		kind_q <= kind_d;
		val_q <= val_d;
		held_ph_q <= held_ph_d;
		held_end_q <= held_end_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			start_q <= 1'b1;
			wlast_q <= '0;
			whas_q <= 1'b0;
			nsp_q <= 1'b0;
			seqne_q <= 1'b0;
			held_vld_q <= 1'b0;
			idx_q <= '0;
			ecnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			start_q <= start_d;
			wlast_q <= wlast_d;
			whas_q <= whas_d;
			nsp_q <= nsp_d;
			seqne_q <= seqne_d;
			held_vld_q <= held_vld_d;
			idx_q <= idx_d;
			ecnt_q <= ecnt_d;
		end
	end

	`LGP_ASSERT_IMPL(a_idle_no_held, clk, arst_n, state_q == S_IDLE, !held_vld_q, "result held in idle")
	`LGP_ASSERT_IMPL(a_idle_window, clk, arst_n, state_q == S_IDLE, cnt_q != 2'd3, "window full in idle")
	`LGP_ASSERT_IMPL(a_emit_index, clk, arst_n, state_q == S_EMIT, idx_q < ecnt_q, "emit index past list")
endmodule

// ----- rtl/core/latin_grapheme_to_phoneme_unit.sv -----
`timescale 1ns / 1ps
// Streams Unicode codepoints in and phoneme codepoints out for Spanish, French or
// Portuguese, chosen by the language register (value 3 acts as Spanish). The front
// lowercases and classifies each beat in the cycle it is taken and drops it into a
// four-entry item queue, so codepoints is ready whenever that queue has room, one beat
// a cycle. The back sequencer keeps the three-letter window and emits one result per
// cycle while the output queue has room: a letter that only fills the window is just
// popped; a letter that completes it is popped, then the rules are evaluated, the
// results (up to three with the word space) are emitted one by one and the item is
// closed; a word end repeats the evaluation for each pending letter. The sequencer
// pops the next item only after it has finished the last one. Results pass through
// a four-entry output queue; last_of_run marks the final result of each input beat,
// and end_of_text always yields a closing result with text_end set and phoneme zero.
// Write language only while the block is idle.
module latin_grapheme_to_phoneme_unit #(
	parameter int QUEUE_DEPTH = lgp_pkg::LGP_QUEUE_DEPTH,
	parameter int OUT_DEPTH = lgp_pkg::LGP_OUT_DEPTH
) (
	input logic clk,
	input logic arst_n,
	lgp_chan_if.sink cfg,
	lgp_chan_if.sink codepoints,
	lgp_chan_if.source phonemes
);
	import lgp_pkg::*;

	// rule set register, always ready
	logic [1:0] language_q;

	// front to back item path
	lgp_item_t item;
	logic item_empty;
	logic item_pop;

	// back to output queue
	logic out_full;
	logic out_empty;
	logic out_push;
	lgp_out_t out_wdata;
	logic [$bits(lgp_out_t)-1:0] out_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			language_q <= '0;
		end else if (cfg.valid) begin
			language_q <= cfg.data.language;
		end
	end

	// classify and queue input beats
	lgp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.codepoints(codepoints),
		.item(item),
		.item_empty(item_empty),
		.item_pop(item_pop)
	);

	// window, rules and result sequencing
	lgp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.lang(language_q),
		.item(item),
		.item_empty(item_empty),
		.item_pop(item_pop),
		.out_full(out_full),
		.push(out_push),
		.push_data(out_wdata)
	);

	// output queue decouples the sequencer from the consumer
	lgp_fifo #(.WIDTH($bits(lgp_out_t)), .DEPTH(OUT_DEPTH)) u_out_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(out_push),
		.wdata(out_wdata),
		.full(out_full),
		.pop(phonemes.valid && phonemes.ready),
		.rdata(out_rdata),
		.empty(out_empty)
	);

	assign phonemes.valid = !out_empty;
	assign phonemes.data = lgp_out_t'(out_rdata);
endmodule
